// ===== src/rbst_pkg.sv =====
package rbst_pkg;

  // Width of every coordinate, ray parameter and register.
  localparam int DataW = 32;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEFAULT = 16;

  // Number of slab lanes: one per box corner coordinate.
  localparam int NumAxes  = 3;
  localparam int NumLanes = 2 * NumAxes;

  // Configuration port address width and register index width.
  localparam int AddrW = 5;
  localparam int IdxW  = 3;

  localparam logic [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [IdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_RECIP_DIR_X = 3'd3,
    REG_RECIP_DIR_Y = 3'd4,
    REG_RECIP_DIR_Z = 3'd5
  } rbst_reg_e;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } rbst_adv_t;

endpackage

// ===== src/rbst_lane.sv =====
module rbst_lane #(
  parameter int FracBits = rbst_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                  clk_i,
  input  rbst_pkg::rbst_adv_t                   adv_i,
  input  logic signed [rbst_pkg::DataW-1:0]     corner_i,
  input  logic signed [rbst_pkg::DataW-1:0]     origin_i,
  input  logic signed [rbst_pkg::DataW-1:0]     recip_i,
  output logic signed [rbst_pkg::DataW-1:0]     param_o
);

  localparam int DW    = rbst_pkg::DataW;
  localparam int DiffW = DW + 1;
  localparam int ProdW = DiffW + DW;
  // The kept field's sign bit and all bits above it, which must all match.
  localparam int TopW  = ProdW - (DW - 1) - FracBits;

  logic signed [DiffW-1:0] diff_d, diff_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic        [TopW-1:0]  top_bits;
  logic                    fits;
  logic signed [DW-1:0]    param_d, param_q;

  assign diff_d = {corner_i[DW-1], corner_i} - {origin_i[DW-1], origin_i};
  assign prod_d = diff_q * recip_i;

  // Floor scaling is a plain arithmetic shift; saturate when the upper bits
  // are not a pure sign extension.
  assign top_bits = prod_q[ProdW-1 -: TopW];
  assign fits     = (&top_bits) || !(|top_bits);

  always_comb begin
    if (fits) begin
      param_d = prod_q[FracBits +: DW];
    end else if (prod_q[ProdW-1]) begin
      param_d = rbst_pkg::SatMin;
    end else begin
      param_d = rbst_pkg::SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      diff_q <= diff_d;
    end
    if (adv_i.s2) begin
      prod_q <= prod_d;
    end
    if (adv_i.s3) begin
      param_q <= param_d;
    end
  end

  assign param_o = param_q;

endmodule

// ===== src/rbst_merge.sv =====
module rbst_merge (
  input  logic                              clk_i,
  input  rbst_pkg::rbst_adv_t               adv_i,
  input  logic signed [rbst_pkg::DataW-1:0] param_i [rbst_pkg::NumLanes],
  input  logic signed [rbst_pkg::DataW-1:0] ts_i,
  input  logic signed [rbst_pkg::DataW-1:0] te_i,
  output logic                              hit_o
);

  localparam int DW = rbst_pkg::DataW;
  localparam int NA = rbst_pkg::NumAxes;

  logic signed [DW-1:0] amin_d [NA];
  logic signed [DW-1:0] amax_d [NA];
  logic signed [DW-1:0] amin_q [NA];
  logic signed [DW-1:0] amax_q [NA];
  logic signed [DW-1:0] ts_q, te_q;
  logic signed [DW-1:0] near_t, far_t;
  logic                 hit_d, hit_q;

  // Lanes 0..2 carry the low corner, lanes 3..5 the high corner of each axis.
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      if (param_i[k] < param_i[k+NA]) begin
        amin_d[k] = param_i[k];
        amax_d[k] = param_i[k+NA];
      end else begin
        amin_d[k] = param_i[k+NA];
        amax_d[k] = param_i[k];
      end
    end
  end

  always_comb begin
    near_t = ts_q;
    far_t  = te_q;
    for (int k = 0; k < NA; k++) begin
      if (amin_q[k] > near_t) begin
        near_t = amin_q[k];
      end
      if (amax_q[k] < far_t) begin
        far_t = amax_q[k];
      end
    end
    // An interval lying wholly inside the box counts as a miss.
    if (near_t <= ts_q && far_t >= te_q) begin
      hit_d = 1'b0;
    end else begin
      hit_d = (near_t <= far_t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      amin_q <= amin_d;
      amax_q <= amax_d;
      ts_q   <= ts_i;
      te_q   <= te_i;
    end
    if (adv_i.s5) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== src/ray_box_slab_test_unit.sv =====
// Channel   Handshake                     Payload
// in        in_valid_i / in_stall_o       box_lo_{x,y,z}_i, box_hi_{x,y,z}_i,
//                                         interval_start_i, interval_end_i
// out       out_valid_o / out_stall_i     hit_o
// config    psel/penable/pwrite/pready    paddr, pwdata, prdata (APB style)
//
// One request is accepted per cycle while in_stall_o is low, and each gives
// one result through the five-stage pipeline: subtract, multiply, scale and
// saturate, per-axis ordering, final merge.
// Reset clears the stage valid bits and loads the ray registers (origin zero,
// reciprocal direction one). Each stage holds while the stage after it is
// full and stalled, so bubbles collapse and a request is still taken while a
// finished result waits at the output.
module ray_box_slab_test_unit #(
  parameter int FracBits = rbst_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rbst_pkg::DataW-1:0]     box_lo_x_i,
  input  logic signed [rbst_pkg::DataW-1:0]     box_lo_y_i,
  input  logic signed [rbst_pkg::DataW-1:0]     box_lo_z_i,
  input  logic signed [rbst_pkg::DataW-1:0]     box_hi_x_i,
  input  logic signed [rbst_pkg::DataW-1:0]     box_hi_y_i,
  input  logic signed [rbst_pkg::DataW-1:0]     box_hi_z_i,
  input  logic signed [rbst_pkg::DataW-1:0]     interval_start_i,
  input  logic signed [rbst_pkg::DataW-1:0]     interval_end_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  hit_o,

  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [rbst_pkg::AddrW-1:0]     paddr,
  input  logic        [rbst_pkg::DataW-1:0]     pwdata,
  output logic        [rbst_pkg::DataW-1:0]     prdata,
  output logic                                  pready
);

  localparam int DW    = rbst_pkg::DataW;
  localparam int NL    = rbst_pkg::NumLanes;
  localparam int NA    = rbst_pkg::NumAxes;
  localparam int NumSt = 5;

  // Fixed-point one, the reset value of each reciprocal direction register.
  localparam logic [DW-1:0] RecipOne = DW'(64'd1 << FracBits);

  // ---------------------------------------------------------------------
  // Ray registers behind the configuration port.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] origin_q [NA];
  logic signed [DW-1:0] recip_q  [NA];
  logic                 cfg_wr;
  rbst_pkg::rbst_reg_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rbst_pkg::rbst_reg_e'(paddr[rbst_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        origin_q[k] <= '0;
        recip_q[k]  <= RecipOne;
      end
    end else if (cfg_wr) begin
      // Writes to addresses past the last register fall through unused.
      unique case (cfg_idx)
        rbst_pkg::REG_ORIGIN_X:    origin_q[0] <= pwdata;
        rbst_pkg::REG_ORIGIN_Y:    origin_q[1] <= pwdata;
        rbst_pkg::REG_ORIGIN_Z:    origin_q[2] <= pwdata;
        rbst_pkg::REG_RECIP_DIR_X: recip_q[0]  <= pwdata;
        rbst_pkg::REG_RECIP_DIR_Y: recip_q[1]  <= pwdata;
        rbst_pkg::REG_RECIP_DIR_Z: recip_q[2]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rbst_pkg::REG_ORIGIN_X:    prdata = origin_q[0];
      rbst_pkg::REG_ORIGIN_Y:    prdata = origin_q[1];
      rbst_pkg::REG_ORIGIN_Z:    prdata = origin_q[2];
      rbst_pkg::REG_RECIP_DIR_X: prdata = recip_q[0];
      rbst_pkg::REG_RECIP_DIR_Y: prdata = recip_q[1];
      rbst_pkg::REG_RECIP_DIR_Z: prdata = recip_q[2];
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. Stage k may load whenever it is empty or the
  // stage after it loads in the same cycle; the last stage drains into the
  // output channel.
  // ---------------------------------------------------------------------
  logic [NumSt-1:0] valid_d, valid_q;
  logic [NumSt-1:0] ready;
  rbst_pkg::rbst_adv_t adv;

  always_comb begin
    ready[NumSt-1] = !valid_q[NumSt-1] || !out_stall_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    // The first stage takes the input channel, every later stage the one
    // before it.
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end else begin
      valid_d[0] = valid_q[0];
    end
    for (int k = 1; k < NumSt; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign adv.s1 = ready[0];
  assign adv.s2 = ready[1];
  assign adv.s3 = ready[2];
  assign adv.s4 = ready[3];
  assign adv.s5 = ready[4];

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NumSt-1];

  // ---------------------------------------------------------------------
  // Interval limits ride alongside the three lane stages.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] ts_q [3];
  logic signed [DW-1:0] te_q [3];

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      ts_q[0] <= interval_start_i;
      te_q[0] <= interval_end_i;
    end
    if (adv.s2) begin
      ts_q[1] <= ts_q[0];
      te_q[1] <= te_q[0];
    end
    if (adv.s3) begin
      ts_q[2] <= ts_q[1];
      te_q[2] <= te_q[1];
    end
  end

  // ---------------------------------------------------------------------
  // Six slab lanes: the low corner of each axis in lanes 0 to 2, the high
  // corner in lanes 3 to 5. Each lane forms one saturated slab parameter.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] corner [NL];
  logic signed [DW-1:0] param  [NL];

  assign corner[0] = box_lo_x_i;
  assign corner[1] = box_lo_y_i;
  assign corner[2] = box_lo_z_i;
  assign corner[3] = box_hi_x_i;
  assign corner[4] = box_hi_y_i;
  assign corner[5] = box_hi_z_i;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    rbst_lane #(
      .FracBits (FracBits)
    ) u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .corner_i (corner[g]),
      .origin_i (origin_q[g % NA]),
      .recip_i  (recip_q[g % NA]),
      .param_o  (param[g])
    );
  end

  // The merge stage orders each axis pair, then folds the axes together
  // with the interval limits and decides the hit.
  rbst_merge u_merge (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .param_i (param),
    .ts_i    (ts_q[2]),
    .te_i    (te_q[2]),
    .hit_o   (hit_o)
  );

endmodule

// ===== tb/sv/ray_box_slab_test_unit_tb.sv =====
module ray_box_slab_test_unit_tb;

  localparam int DataW   = rbst_pkg::DataW;
  localparam int IdxW    = rbst_pkg::IdxW;
  localparam int AddrW   = rbst_pkg::AddrW;
  localparam int NumAxes = rbst_pkg::NumAxes;
  localparam logic [DataW-1:0] SatMax = rbst_pkg::SatMax;
  localparam logic [DataW-1:0] SatMin = rbst_pkg::SatMin;

  // The block runs at its default fraction width, so the testbench does too.
  localparam int FracBits = rbst_pkg::FRAC_BITS_DEFAULT;
  localparam int One = 1 << FracBits;

  // Five pipeline stages sit between a request and its result. Drain pauses
  // then let the pipeline settle once the last expected result is in.
  localparam int PipeDepth = 5;
  localparam int SettleCycles = PipeDepth + 3;

  // The run is stopped when the watchdog count reaches this limit with no handshake or configuration cycle.
  localparam int WatchdogLimit = 2000;

  // Length of the long receiver hold-off used to fill the pipeline.
  localparam int RxHoldCycles = 80;

  // Random traffic: boxes per ray setting, three idling phases in all.
  localparam int MildRayBoxes = 450;
  localparam int ExtremeRayBoxes = 200;

  // Register slots that decode to no register. Writes there must be ignored.
  localparam logic [IdxW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [IdxW-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam int NumRegs = rbst_pkg::REG_RECIP_DIR_Z + 1;

  // Saturation bounds of a slab parameter, widened to the product width.
  localparam logic signed [2*DataW+1:0] SlabParamMax = $signed({{(DataW+2){1'b0}}, SatMax});
  localparam logic signed [2*DataW+1:0] SlabParamMin = $signed({{(DataW+2){1'b1}}, SatMin});

  // One box request: both corners per axis plus the ray interval.
  typedef struct packed {
    logic [NumAxes-1:0][DataW-1:0] lo;
    logic [NumAxes-1:0][DataW-1:0] hi;
    logic [DataW-1:0]              t_start;
    logic [DataW-1:0]              t_end;
  } box_req_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DataW-1:0]  box_lo_x_i;
  logic signed [DataW-1:0]  box_lo_y_i;
  logic signed [DataW-1:0]  box_lo_z_i;
  logic signed [DataW-1:0]  box_hi_x_i;
  logic signed [DataW-1:0]  box_hi_y_i;
  logic signed [DataW-1:0]  box_hi_z_i;
  logic signed [DataW-1:0]  interval_start_i;
  logic signed [DataW-1:0]  interval_end_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     hit_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  // Our own copy of the ray registers, indexed by register code. It follows
  // every configuration write so the predictor always sees what the block has.
  logic signed [DataW-1:0]  ray_reg [NumRegs];

  // Expected hit flags, oldest first, one per accepted request.
  bit                       hit_expect_q [$];
  bit                       hit_expected;

  int                       mismatch_count;
  int                       quiet_cycles;

  // Idling knobs, changed between phases by the test sequence. The sender
  // inserts a gap before a request with tx_idle_pct percent probability and
  // the receiver stalls each cycle with rx_stall_pct percent probability.
  int                       tx_idle_pct;
  int                       rx_stall_pct;
  bit                       rx_hold_req;

  ray_box_slab_test_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .box_lo_x_i       (box_lo_x_i),
    .box_lo_y_i       (box_lo_y_i),
    .box_lo_z_i       (box_lo_z_i),
    .box_hi_x_i       (box_hi_x_i),
    .box_hi_y_i       (box_hi_y_i),
    .box_hi_z_i       (box_hi_z_i),
    .interval_start_i (interval_start_i),
    .interval_end_i   (interval_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Ray parameter at which the ray crosses one slab plane. The difference is
  // exact at 33 bits and the product exact at 66 bits. The arithmetic shift
  // rounds toward minus infinity, and the result saturates to 32 bits.
  function automatic logic signed [DataW-1:0] slab_param(
    input logic signed [DataW-1:0] corner,
    input logic signed [DataW-1:0] origin,
    input logic signed [DataW-1:0] recip
  );
    logic signed [DataW:0]     diff;
    logic signed [2*DataW+1:0] scaled;
    diff   = corner - origin;
    scaled = (diff * recip) >>> FracBits;
    if (scaled > SlabParamMax) begin
      return SatMax;
    end
    if (scaled < SlabParamMin) begin
      return SatMin;
    end
    return scaled[DataW-1:0];
  endfunction

  // Full slab test of one box against the configured ray. Entry starts at
  // the interval start and only moves later. Exit starts at the interval
  // end and only moves earlier. An interval that no slab narrows lies wholly
  // inside the box, and the block reports that as a miss.
  function automatic bit slab_hit(input box_req_t b);
    logic signed [DataW-1:0] t_entry;
    logic signed [DataW-1:0] t_exit;
    logic signed [DataW-1:0] ta;
    logic signed [DataW-1:0] tb_;
    t_entry = $signed(b.t_start);
    t_exit  = $signed(b.t_end);
    for (int k = 0; k < NumAxes; k++) begin
      ta  = slab_param($signed(b.lo[k]), ray_reg[rbst_pkg::REG_ORIGIN_X + k],
                       ray_reg[rbst_pkg::REG_RECIP_DIR_X + k]);
      tb_ = slab_param($signed(b.hi[k]), ray_reg[rbst_pkg::REG_ORIGIN_X + k],
                       ray_reg[rbst_pkg::REG_RECIP_DIR_X + k]);
      // Swapped corners are sorted here, exactly as for an ordered box.
      if (ta > tb_) begin
        {ta, tb_} = {tb_, ta};
      end
      if (ta > t_entry) begin
        t_entry = ta;
      end
      if (tb_ < t_exit) begin
        t_exit = tb_;
      end
    end
    if (t_entry <= $signed(b.t_start) && t_exit >= $signed(b.t_end)) begin
      return 1'b0;
    end
    return t_entry <= t_exit;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // One write: a setup cycle, then an access cycle that completes at the
  // edge where pready is high. A cycle with psel low follows, so the next
  // transfer starts in a new time step.
  task automatic reg_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Slots past the last register decode to nothing and leave the ray as is.
    if (idx <= rbst_pkg::REG_RECIP_DIR_Z) begin
      ray_reg[idx] = value;
    end
    @(posedge clk_i);
  endtask

  // Reads one register back and compares it with our copy.
  task automatic check_readback(input rbst_pkg::rbst_reg_e r);
    logic [DataW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({r, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== ray_reg[r]) begin
      $error("%s: expected %h, actual %h", r.name(), ray_reg[r], got);
      mismatch_count++;
    end
    @(posedge clk_i);
  endtask

  // Loads a whole ray. A mild ray has its origin near zero and a reciprocal
  // direction between 1/16 and 16 of either sign, so boxes placed around the
  // origin give a healthy mix of hits and misses. An extreme ray takes each
  // register from the range ends, zero or a random value, the reciprocal also
  // from plus and minus one, and drives most products into saturation.
  task automatic load_ray(input bit extreme);
    logic [DataW-1:0] value;
    for (int k = 0; k < NumAxes; k++) begin
      if (!extreme) begin
        value = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      end else begin
        case ($urandom_range(3))
          0:       value = SatMin;
          1:       value = SatMax;
          2:       value = '0;
          default: value = $urandom();
        endcase
      end
      reg_write(IdxW'(rbst_pkg::REG_ORIGIN_X + k), value);
    end
    for (int k = 0; k < NumAxes; k++) begin
      if (!extreme) begin
        value = int'($urandom_range(1 << 12, 1 << 20));
        if ($urandom_range(1) == 1) begin
          value = -value;
        end
      end else begin
        case ($urandom_range(5))
          0:       value = SatMin;
          1:       value = SatMax;
          2:       value = '0;
          3:       value = One;
          4:       value = -One;
          default: value = $urandom();
        endcase
      end
      reg_write(IdxW'(rbst_pkg::REG_RECIP_DIR_X + k), value);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one box. Random gaps come first with valid low. Then the request is
  // held, unchanged, until an edge where the block does not stall it. The
  // expected hit is queued at that edge. Valid stays high on return, so the
  // next request follows back to back unless a gap or a drain lowers it.
  task automatic send_box(input box_req_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    box_lo_x_i       <= b.lo[0];
    box_lo_y_i       <= b.lo[1];
    box_lo_z_i       <= b.lo[2];
    box_hi_x_i       <= b.hi[0];
    box_hi_y_i       <= b.hi[1];
    box_hi_z_i       <= b.hi[2];
    interval_start_i <= b.t_start;
    interval_end_i   <= b.t_end;
    do @(posedge clk_i); while (in_stall_o);
    hit_expect_q.push_back(slab_hit(b));
  endtask

  // Lowers valid and waits until every expected result is in. It then lets
  // the pipeline settle, so the block is idle for a register write.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hit_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic box_req_t make_box(
    input int lo_x, input int lo_y, input int lo_z,
    input int hi_x, input int hi_y, input int hi_z,
    input int t_start, input int t_end
  );
    box_req_t b;
    b.lo[0]   = lo_x;
    b.lo[1]   = lo_y;
    b.lo[2]   = lo_z;
    b.hi[0]   = hi_x;
    b.hi[1]   = hi_y;
    b.hi[2]   = hi_z;
    b.t_start = t_start;
    b.t_end   = t_end;
    return b;
  endfunction

  function automatic int rand_offset(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random box traffic. Most boxes are placed relative to the current
  // origin, so the slab parameters land in a useful range. Such boxes either
  // enclose the origin, so the ray always crosses all slabs, or sit near it.
  // Some near boxes get swapped corners and reversed intervals, some big boxes
  // hold tiny intervals, and the rest are plain noise over the full 32-bit range.
  function automatic box_req_t random_box();
    box_req_t         b;
    int               mode;
    int               span;
    logic [DataW-1:0] org;
    mode      = $urandom_range(99);
    span      = int'($urandom_range(1, 1 << 20));
    b.t_start = rand_offset(span);
    b.t_end   = b.t_start + int'($urandom_range(0, 2 * span));
    for (int k = 0; k < NumAxes; k++) begin
      org = ray_reg[rbst_pkg::REG_ORIGIN_X + k];
      if (mode < 40) begin
        b.lo[k] = org - int'($urandom_range(0, span));
        b.hi[k] = org + int'($urandom_range(0, span));
      end else if (mode < 80) begin
        b.lo[k] = org + rand_offset(span);
        b.hi[k] = b.lo[k] + int'($urandom_range(0, span));
        if (mode >= 70 && $urandom_range(1) == 1) begin
          {b.lo[k], b.hi[k]} = {b.hi[k], b.lo[k]};
        end
      end else begin
        b.lo[k] = org - (1 << 24) - int'($urandom_range(0, span));
        b.hi[k] = org + (1 << 24) + int'($urandom_range(0, span));
      end
    end
    if (mode >= 70 && mode < 80 && $urandom_range(1) == 1) begin
      {b.t_start, b.t_end} = {b.t_end, b.t_start};
    end
    if (mode >= 80 && mode < 88) begin
      b.t_start = rand_offset(256);
      b.t_end   = b.t_start + int'($urandom_range(0, 512));
    end
    if (mode >= 88) begin
      b = {$urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver stalls at random. When a hold-off is requested, it keeps
  // stall high for a long stretch, counted here, so the pipeline fills and
  // the block must stall its own input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RxHoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Every result taken at an edge is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_expect_q.size() == 0) begin
        $error("hit: expected no result, actual %0b", hit_o);
        mismatch_count++;
      end else begin
        hit_expected = hit_expect_q.pop_front();
        if (hit_o !== hit_expected) begin
          $error("hit: expected %0b, actual %0b", hit_expected, hit_o);
          mismatch_count++;
        end
      end
    end
  end

  // The watchdog restarts its count at every handshake on either channel and
  // on every configuration cycle. A run that stops moving ends as a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With the reset ray (origin zero, unit reciprocal direction) each slab
  // parameter equals its corner value, so hand-built boxes hit exact edges.
  task automatic test_reset_ray();
    send_box(make_box(One, One, One, 2*One, 2*One, 2*One, 0, 4*One));
    // The y slab starts after the x slab ends, so this one misses.
    send_box(make_box(One, 3*One, One, 2*One, 4*One, 2*One, 0, 8*One));
    // Interval lies inside the box and is reported as a miss.
    send_box(make_box(-10*One, -10*One, -10*One, 10*One, 10*One, 10*One, 0, One));
    // Swapped corners behave like the ordered box above.
    send_box(make_box(2*One, 2*One, 2*One, One, One, One, 0, 4*One));
    // Reversed interval.
    send_box(make_box(One, One, One, 2*One, 2*One, 2*One, 4*One, 0));
    // Slabs touching at a single point still count as a hit.
    send_box(make_box(One, 2*One, 0, 2*One, 3*One, 8*One, 0, 8*One));
    // Interval ending exactly at entry is a hit; one step earlier, a miss.
    send_box(make_box(One, One, One, 2*One, 2*One, 2*One, 0, One));
    send_box(make_box(One, One, One, 2*One, 2*One, 2*One, 0, One - 1));
    // Interval equal to the box span is the inside case again.
    send_box(make_box(One, One, One, 2*One, 2*One, 2*One, One, 2*One));
    // Field extremes.
    send_box(make_box(SatMin, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin));
    send_box(make_box(SatMax, SatMax, SatMax, SatMax, SatMax, SatMax, SatMax, SatMax));
    send_box(make_box(SatMin, SatMin, SatMin, SatMax, SatMax, SatMax, SatMin, SatMax));
    send_box(make_box(SatMax, SatMax, SatMax, SatMin, SatMin, SatMin, 0, One));
    send_box(make_box(0, 0, 0, SatMax, SatMax, SatMax, -One, One));
    wait_drained();
  endtask

  // Every register takes both range ends and is read back. Writes to the
  // unmapped slots must leave all six registers untouched.
  task automatic test_register_access();
    rbst_pkg::rbst_reg_e r;
    r = r.first();
    do begin
      reg_write(r, SatMin);
      check_readback(r);
      reg_write(r, SatMax);
      check_readback(r);
      r = r.next();
    end while (r != r.first());
    reg_write(REG_UNMAPPED_LO, $urandom());
    reg_write(REG_UNMAPPED_HI, $urandom());
    r = r.first();
    do begin
      check_readback(r);
      r = r.next();
    end while (r != r.first());
  endtask

  // Ray at the range ends: x starts at the lowest origin with the largest
  // reciprocal, y mirrors that, and z has a zero reciprocal. Nearly every
  // product saturates one way or the other.
  task automatic test_saturation();
    reg_write(rbst_pkg::REG_ORIGIN_X, SatMin);
    reg_write(rbst_pkg::REG_ORIGIN_Y, SatMax);
    reg_write(rbst_pkg::REG_ORIGIN_Z, '0);
    reg_write(rbst_pkg::REG_RECIP_DIR_X, SatMax);
    reg_write(rbst_pkg::REG_RECIP_DIR_Y, SatMin);
    reg_write(rbst_pkg::REG_RECIP_DIR_Z, '0);
    send_box(make_box(SatMax, SatMax, SatMax, SatMax, SatMax, SatMax, SatMin, SatMax));
    send_box(make_box(SatMin, SatMin, SatMin, SatMin, SatMin, SatMin, SatMin, SatMax));
    send_box(make_box(SatMin, SatMin, SatMin, SatMax, SatMax, SatMax, 0, One));
    send_box(make_box(SatMax, SatMax, SatMax, SatMin, SatMin, SatMin, -One, 0));
    send_box(make_box(0, 0, 0, One, One, One, SatMin, 0));
    send_box(make_box(0, 0, 0, One, One, One, SatMax, SatMax));
    send_box(make_box(0, 0, 0, One, One, One, SatMin, SatMin));
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender offers back to
  // back requests. The pipeline fills up and the input stall must hold the
  // pending request without losing or duplicating it.
  task automatic test_backpressure();
    load_ray(1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b1;
    repeat (40) send_box(random_box());
    wait_drained();
  endtask

  // Three idling phases: a mostly idle receiver, then a mostly idle sender,
  // then full rate both ways. Each phase runs a mild ray, then an extreme one.
  task automatic test_random_traffic();
    int tx_pct [3];
    int rx_pct [3];
    tx_pct[0] = 20;
    rx_pct[0] = 69;
    tx_pct[1] = 69;
    rx_pct[1] = 20;
    tx_pct[2] = 0;
    rx_pct[2] = 0;
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      load_ray(1'b0);
      repeat (MildRayBoxes) send_box(random_box());
      wait_drained();
      load_ray(1'b1);
      repeat (ExtremeRayBoxes) send_box(random_box());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    box_lo_x_i       = '0;
    box_lo_y_i       = '0;
    box_lo_z_i       = '0;
    box_hi_x_i       = '0;
    box_hi_y_i       = '0;
    box_hi_z_i       = '0;
    interval_start_i = '0;
    interval_end_i   = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    rx_hold_req      = 1'b0;

    // Reset loads the ray registers with origin zero and unit direction.
    for (int k = 0; k < NumAxes; k++) begin
      ray_reg[rbst_pkg::REG_ORIGIN_X + k]    = '0;
      ray_reg[rbst_pkg::REG_RECIP_DIR_X + k] = One;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_ray();
    test_register_access();
    test_saturation();
    test_backpressure();
    test_random_traffic();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
